>>> rtl/send_queue_byte_budget_core_assert.svh
// ----------------------------------------------------------------------------
// send queue byte budget assertion macros
// shared concurrent assertion forms for the send queue rtl
// ----------------------------------------------------------------------------
`ifndef SEND_QUEUE_BYTE_BUDGET_CORE_ASSERT_SVH
`define SEND_QUEUE_BYTE_BUDGET_CORE_ASSERT_SVH

// same-cycle implication
`define SQBB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SQBB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sqbb_pkg.sv
// ----------------------------------------------------------------------------
// sqbb_pkg
// types, widths and codes shared by the send queue byte budget rtl
// ----------------------------------------------------------------------------
package sqbb_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int KIND_W  = 2;
   localparam int LEN_W   = 16;
   localparam int ATT_W   = 16;
   localparam int ID_W    = 32;
   localparam int ITEMS_W = 5;
   localparam int BYTES_W = 21;
   localparam int ERR_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = BYTES_W;

   localparam logic [ITEMS_W-1:0] MAX_ITEMS_RESET = ITEMS_W'(16);
   localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = BYTES_W'(1048576);

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITEMS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BYTES = CSR_IDX_W'(1);

   typedef enum logic [KIND_W-1:0] {
      KIND_ENQUEUE  = 2'd0,
      KIND_WRITTEN  = 2'd1,
      KIND_COMPLETE = 2'd2,
      KIND_CANCEL   = 2'd3
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE       = 4'd0,
      ERR_EMPTY_LOAD = 4'd1,
      ERR_FULL       = 4'd2,
      ERR_BUDGET     = 4'd3,
      ERR_QUEUE_EMPTY = 4'd4,
      ERR_FAILED     = 4'd5,
      ERR_INCOMPLETE = 4'd6,
      ERR_ZERO_BYTES = 4'd7,
      ERR_OVERSHOOT  = 4'd8
   } err_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [ID_W-1:0]  ident;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } store_cmd_type;

   typedef struct packed {
      logic [BYTES_W-1:0] total;
      logic [ID_W-1:0]    last_id;
      logic [LEN_W-1:0]   head_off;
      logic [ATT_W-1:0]   head_att;
   } core_state_type;

   typedef struct packed {
      logic               accepted;
      err_type            error_code;
      logic [ID_W-1:0]    new_item_id;
      logic [BYTES_W-1:0] outstanding;
      logic [ID_W-1:0]    head_id;
      logic [LEN_W-1:0]   head_remaining;
      logic [ATT_W-1:0]   head_attempts;
   } result_type;

endpackage

>>> rtl/sqbb_store.sv
// ----------------------------------------------------------------------------
// sqbb_store
// entry line: written at the fill position, shifted toward slot zero on pop,
// so the head is always slot zero and the following entry slot one
// ----------------------------------------------------------------------------
module sqbb_store #(
   parameter int DEPTH = sqbb_pkg::DEPTH_DEFAULT,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  sqbb_pkg::store_cmd_type cmd,
   input  logic [IDX_W-1:0]        wr_index,
   input  sqbb_pkg::entry_type     wr_entry,
   output sqbb_pkg::entry_type     head_entry,
   output sqbb_pkg::entry_type     next_entry
);
   import sqbb_pkg::*;

   entry_type slot_ff [DEPTH];

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (cmd.push && (wr_index == IDX_W'(i))) begin
            slot_ff[i] <= wr_entry;
         end else if (cmd.pop && (i < DEPTH - 1)) begin
            slot_ff[i] <= slot_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   assign head_entry = slot_ff[0];

   generate
      if (DEPTH > 1) begin : g_next
         assign next_entry = slot_ff[1];
      end else begin : g_no_next
         assign next_entry = '0;
      end
   endgenerate

endmodule

>>> rtl/sqbb_exec.sv
// ----------------------------------------------------------------------------
// sqbb_exec
// per-request decision logic: checks, next counters, entry line command and
// the post-request view of the queue head
// ----------------------------------------------------------------------------
module sqbb_exec #(
   parameter int DEPTH = sqbb_pkg::DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  sqbb_pkg::kind_type             kind,
   input  logic [sqbb_pkg::LEN_W-1:0]     payload_length,
   input  logic [sqbb_pkg::LEN_W-1:0]     written_bytes,
   input  logic                           success,
   input  logic [sqbb_pkg::ITEMS_W-1:0]   max_items,
   input  logic [sqbb_pkg::BYTES_W-1:0]   max_bytes,
   input  logic [CNT_W-1:0]               count,
   input  sqbb_pkg::core_state_type       state,
   input  sqbb_pkg::entry_type            head_entry,
   input  sqbb_pkg::entry_type            next_entry,
   output logic [CNT_W-1:0]               count_next,
   output logic [CNT_W-1:0]               cancelled,
   output sqbb_pkg::core_state_type       state_next,
   output sqbb_pkg::store_cmd_type        cmd,
   output sqbb_pkg::entry_type            wr_entry,
   output sqbb_pkg::result_type           result
);
   import sqbb_pkg::*;

   localparam int LIM_W = (CNT_W > ITEMS_W) ? CNT_W : ITEMS_W;

   logic [LIM_W-1:0]   limit;
   logic [LIM_W-1:0]   items_ext;
   logic [BYTES_W-1:0] budget;
   logic [BYTES_W:0]   sum;
   logic [LEN_W-1:0]   head_rem;
   logic [ID_W-1:0]    id_inc;
   logic [ATT_W-1:0]   att_bump;
   logic [LEN_W-1:0]   sel_len;
   logic [ID_W-1:0]    sel_id;
   logic               enq_empty;

   always_comb begin
      items_ext = LIM_W'(max_items);
      if (items_ext == '0) begin
         limit = LIM_W'(1);
      end else if (items_ext > LIM_W'(DEPTH)) begin
         limit = LIM_W'(DEPTH);
      end else begin
         limit = items_ext;
      end
      budget = (max_bytes == '0) ? BYTES_W'(1) : max_bytes;
   end

   assign sum      = {1'b0, state.total} + (BYTES_W + 1)'(payload_length);
   assign head_rem = head_entry.len - state.head_off;
   assign id_inc   = state.last_id + ID_W'(1);
   assign att_bump = (state.head_att == '1) ? state.head_att : state.head_att + ATT_W'(1);

   assign wr_entry.len   = payload_length;
   assign wr_entry.ident = id_inc;

   always_comb begin
      count_next = count;
      cancelled  = '0;
      state_next = state;
      cmd        = '0;
      enq_empty  = 1'b0;
      result     = '0;
      result.error_code = ERR_NONE;
      case (kind)
         KIND_ENQUEUE: begin
            if (payload_length == '0) begin
               result.error_code = ERR_EMPTY_LOAD;
            end else if (LIM_W'(count) >= limit) begin
               result.error_code = ERR_FULL;
            end else if (sum > {1'b0, budget}) begin
               result.error_code = ERR_BUDGET;
            end else begin
               cmd.push           = 1'b1;
               enq_empty          = (count == '0);
               count_next         = count + CNT_W'(1);
               state_next.total   = sum[BYTES_W-1:0];
               state_next.last_id = id_inc;
               result.new_item_id = id_inc;
               result.accepted    = 1'b1;
            end
         end
         KIND_WRITTEN: begin
            if (count == '0) begin
               result.error_code = ERR_QUEUE_EMPTY;
            end else if (written_bytes == '0) begin
               result.error_code = ERR_ZERO_BYTES;
            end else if (written_bytes > head_rem) begin
               state_next.head_att = att_bump;
               result.error_code   = ERR_OVERSHOOT;
            end else begin
               state_next.head_off = state.head_off + written_bytes;
               state_next.total    = (BYTES_W'(written_bytes) >= state.total) ? '0 :
                                     state.total - BYTES_W'(written_bytes);
               result.accepted     = 1'b1;
            end
         end
         KIND_COMPLETE: begin
            if (count == '0) begin
               result.error_code = ERR_QUEUE_EMPTY;
            end else if (!success) begin
               state_next.head_att = att_bump;
               result.error_code   = ERR_FAILED;
            end else if (state.head_off < head_entry.len) begin
               state_next.head_att = att_bump;
               result.error_code   = ERR_INCOMPLETE;
            end else begin
               cmd.pop             = 1'b1;
               count_next          = count - CNT_W'(1);
               state_next.head_off = '0;
               state_next.head_att = '0;
               result.accepted     = 1'b1;
            end
         end
         KIND_CANCEL: begin
            cancelled           = count;
            count_next          = '0;
            state_next.total    = '0;
            state_next.head_off = '0;
            state_next.head_att = '0;
            result.accepted     = 1'b1;
         end
         default: begin
            result.error_code = ERR_NONE;
         end
      endcase

      // head after this request
      if (cmd.pop) begin
         sel_len = next_entry.len;
         sel_id  = next_entry.ident;
      end else if (enq_empty) begin
         sel_len = payload_length;
         sel_id  = id_inc;
      end else begin
         sel_len = head_entry.len;
         sel_id  = head_entry.ident;
      end
      result.outstanding = state_next.total;
      if (count_next != '0) begin
         result.head_id        = sel_id;
         result.head_remaining = sel_len - state_next.head_off;
         result.head_attempts  = state_next.head_att;
      end
   end

endmodule

>>> rtl/send_queue_byte_budget_core.sv
// the response to an accepted request is registered and shows on the rsp port in the cycle after
// throughput: one request per cycle while the response port is not stalled, set by the
// single decision pass between the queue state registers and the response register
// reset: synchronous, clears the queue, counters, id counter and limits to
// their defaults; entry contents are not cleared and no clearing pass is run
// ----------------------------------------------------------------------------
// send_queue_byte_budget_core
// transmit descriptor queue with an entry limit and an outstanding byte budget
// ----------------------------------------------------------------------------
`include "send_queue_byte_budget_core_assert.svh"

module send_queue_byte_budget_core #(
   parameter int DEPTH = sqbb_pkg::DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1),
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              csr_write,
   input  logic [sqbb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sqbb_pkg::CSR_DATA_W-1:0]   csr_wdata,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sqbb_pkg::KIND_W-1:0]       req_kind,
   input  logic [sqbb_pkg::LEN_W-1:0]        req_payload_length,
   input  logic [sqbb_pkg::LEN_W-1:0]        req_written_bytes,
   input  logic                              req_success,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_accepted,
   output logic [sqbb_pkg::ERR_W-1:0]        rsp_error_code,
   output logic [sqbb_pkg::ID_W-1:0]         rsp_new_item_id,
   output logic [CNT_W-1:0]                  rsp_cancelled_count,
   output logic [CNT_W-1:0]                  rsp_pending_count,
   output logic [sqbb_pkg::BYTES_W-1:0]      rsp_outstanding_bytes,
   output logic [sqbb_pkg::ID_W-1:0]         rsp_head_id,
   output logic [sqbb_pkg::LEN_W-1:0]        rsp_head_remaining,
   output logic [sqbb_pkg::ATT_W-1:0]        rsp_head_attempts
);
   import sqbb_pkg::*;

   logic [ITEMS_W-1:0] max_items_ff;
   logic [BYTES_W-1:0] max_bytes_ff;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   core_state_type     state_ff;
   core_state_type     state_in;

   logic               rsp_valid_ff;
   result_type         rsp_result_ff;
   logic [CNT_W-1:0]   rsp_cancelled_ff;
   logic [CNT_W-1:0]   rsp_pending_ff;

   logic               req_accept;
   store_cmd_type      exec_cmd;
   store_cmd_type      store_cmd;
   entry_type          wr_entry;
   entry_type          head_entry;
   entry_type          next_entry;
   logic [CNT_W-1:0]   cancelled;
   result_type         result;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   sqbb_exec #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_exec (
      .kind           (kind_type'(req_kind)),
      .payload_length (req_payload_length),
      .written_bytes  (req_written_bytes),
      .success        (req_success),
      .max_items      (max_items_ff),
      .max_bytes      (max_bytes_ff),
      .count          (count_ff),
      .state          (state_ff),
      .head_entry     (head_entry),
      .next_entry     (next_entry),
      .count_next     (count_in),
      .cancelled      (cancelled),
      .state_next     (state_in),
      .cmd            (exec_cmd),
      .wr_entry       (wr_entry),
      .result         (result)
   );

   always_comb begin
      store_cmd.push = exec_cmd.push && req_accept;
      store_cmd.pop  = exec_cmd.pop && req_accept;
   end

   sqbb_store #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock      (clock),
      .cmd        (store_cmd),
      .wr_index   (count_ff[IDX_W-1:0]),
      .wr_entry   (wr_entry),
      .head_entry (head_entry),
      .next_entry (next_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_items_ff <= MAX_ITEMS_RESET;
         max_bytes_ff <= MAX_BYTES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAX_ITEMS: max_items_ff <= csr_wdata[ITEMS_W-1:0];
            CSR_MAX_BYTES: max_bytes_ff <= csr_wdata[BYTES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            count_ff <= count_in;
            state_ff <= state_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_result_ff    <= result;
         rsp_cancelled_ff <= cancelled;
         rsp_pending_ff   <= count_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_accepted          = rsp_result_ff.accepted;
   assign rsp_error_code        = rsp_result_ff.error_code;
   assign rsp_new_item_id       = rsp_result_ff.new_item_id;
   assign rsp_cancelled_count   = rsp_cancelled_ff;
   assign rsp_pending_count     = rsp_pending_ff;
   assign rsp_outstanding_bytes = rsp_result_ff.outstanding;
   assign rsp_head_id           = rsp_result_ff.head_id;
   assign rsp_head_remaining    = rsp_result_ff.head_remaining;
   assign rsp_head_attempts     = rsp_result_ff.head_attempts;

   `SQBB_ASSERT_NOW(a_ok_matches_code, clock, reset, rsp_valid_ff, rsp_result_ff.accepted == (rsp_result_ff.error_code == ERR_NONE), "accepted flag disagrees with error code")
   `SQBB_ASSERT_NOW(a_empty_head_clean, clock, reset, count_ff == '0, (state_ff.head_off == '0) && (state_ff.head_att == '0), "head progress left over on empty queue")
   `SQBB_ASSERT_NEXT(a_push_counts, clock, reset, req_accept && exec_cmd.push, count_ff == $past(count_ff) + CNT_W'(1), "enqueue did not raise entry count")
   `SQBB_ASSERT_NOW(a_empty_rsp_head, clock, reset, rsp_valid_ff && (rsp_pending_ff == '0), (rsp_result_ff.head_id == '0) && (rsp_result_ff.head_remaining == '0), "empty queue reports a head")

endmodule

>>> tb/send_queue_byte_budget_core_test.sv
// ----------------------------------------------------------------------------
// send_queue_byte_budget_core_test
// self-checking bench for the send queue: requests are planned into a backlog
// and driven with random gaps, every response is checked field by field
// against a queue tracker that runs at request acceptance time
// ----------------------------------------------------------------------------
module send_queue_byte_budget_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sqbb_pkg::*;

   localparam int SLOTS       = DEPTH_DEFAULT;
   localparam int WATCH_LIMIT = 2000;
   localparam int SAT_OPS     = 40;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] plen;
      logic [15:0] wbytes;
      logic        ok;
   } request_t;

   typedef struct packed {
      logic        accepted;
      err_type     code;
      logic [31:0] new_id;
      logic [4:0]  cancelled;
      logic [4:0]  pending;
      logic [20:0] outstanding;
      logic [31:0] head_id;
      logic [15:0] head_left;
      logic [15:0] head_att;
   } reply_t;

   logic clock;
   logic reset = 1'b1;

   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MAX_ITEMS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [KIND_W-1:0] req_kind = KIND_ENQUEUE;
   logic [LEN_W-1:0]  req_payload_length = '0;
   logic [LEN_W-1:0]  req_written_bytes = '0;
   logic              req_success = 1'b0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_accepted;
   logic [ERR_W-1:0]  rsp_error_code;
   logic [ID_W-1:0]   rsp_new_item_id;
   logic [4:0]        rsp_cancelled_count;
   logic [4:0]        rsp_pending_count;
   logic [BYTES_W-1:0] rsp_outstanding_bytes;
   logic [ID_W-1:0]   rsp_head_id;
   logic [LEN_W-1:0]  rsp_head_remaining;
   logic [ATT_W-1:0]  rsp_head_attempts;

   // queue tracker state
   logic [15:0] slot_len [SLOTS];
   logic [15:0] slot_off [SLOTS];
   logic [15:0] slot_att [SLOTS];
   logic [31:0] slot_id [SLOTS];
   logic [3:0]  head_slot = '0;
   logic [3:0]  tail_slot = '0;
   logic [4:0]  fill = '0;
   logic [20:0] unsent = '0;
   logic [31:0] last_id = '0;
   logic [4:0]  cfg_items = MAX_ITEMS_RESET;
   logic [20:0] cfg_bytes = MAX_BYTES_RESET;

   // planning shadow: remaining bytes per queued entry
   int unsigned plan_left[$];
   int unsigned plan_bytes = 0;

   request_t backlog[$];
   reply_t   replies_due[$];
   int       requests_planned = 0;
   int       requests_taken = 0;
   int       mismatches = 0;
   int       quiet_cycles = 0;
   int       send_gap = 0;
   int       stall_gap = 0;
   bit       req_taken = 1'b0;
   bit       calm = 1'b0;

   send_queue_byte_budget_core u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_payload_length    (req_payload_length),
      .req_written_bytes     (req_written_bytes),
      .req_success           (req_success),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_accepted          (rsp_accepted),
      .rsp_error_code        (rsp_error_code),
      .rsp_new_item_id       (rsp_new_item_id),
      .rsp_cancelled_count   (rsp_cancelled_count),
      .rsp_pending_count     (rsp_pending_count),
      .rsp_outstanding_bytes (rsp_outstanding_bytes),
      .rsp_head_id           (rsp_head_id),
      .rsp_head_remaining    (rsp_head_remaining),
      .rsp_head_attempts     (rsp_head_attempts)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int items_cap();
      if (cfg_items == 0) return 1;
      if (int'(cfg_items) > SLOTS) return SLOTS;
      return int'(cfg_items);
   endfunction

   function automatic int byte_cap();
      return (cfg_bytes == 0) ? 1 : int'(cfg_bytes);
   endfunction

   function automatic void bump_tries(logic [3:0] s);
      if (slot_att[s] != 16'hFFFF) slot_att[s] = slot_att[s] + 16'd1;
   endfunction

   function automatic reply_t track_request(request_t r);
      reply_t      o;
      logic [3:0]  h;
      logic [15:0] left;
      o = '0;
      o.code = ERR_NONE;
      h = head_slot;
      left = slot_len[h] - slot_off[h];
      case (r.kind)
         KIND_ENQUEUE: begin
            if (r.plen == 0) o.code = ERR_EMPTY_LOAD;
            else if (int'(fill) >= items_cap()) o.code = ERR_FULL;
            else if (int'(unsent) + int'(r.plen) > byte_cap()) o.code = ERR_BUDGET;
            else begin
               last_id = last_id + 32'd1;
               slot_len[tail_slot] = r.plen;
               slot_off[tail_slot] = '0;
               slot_att[tail_slot] = '0;
               slot_id[tail_slot] = last_id;
               tail_slot = tail_slot + 4'd1;
               fill = fill + 5'd1;
               unsent = unsent + 21'(r.plen);
               o.new_id = last_id;
            end
         end
         KIND_WRITTEN: begin
            if (fill == 0) o.code = ERR_QUEUE_EMPTY;
            else if (r.wbytes == 0) o.code = ERR_ZERO_BYTES;
            else if (r.wbytes > left) begin
               bump_tries(h);
               o.code = ERR_OVERSHOOT;
            end else begin
               slot_off[h] = slot_off[h] + r.wbytes;
               unsent = (21'(r.wbytes) >= unsent) ? '0 : unsent - 21'(r.wbytes);
            end
         end
         KIND_COMPLETE: begin
            if (fill == 0) o.code = ERR_QUEUE_EMPTY;
            else if (!r.ok) begin
               bump_tries(h);
               o.code = ERR_FAILED;
            end else if (slot_off[h] < slot_len[h]) begin
               bump_tries(h);
               o.code = ERR_INCOMPLETE;
            end else begin
               head_slot = head_slot + 4'd1;
               fill = fill - 5'd1;
            end
         end
         default: begin
            o.cancelled = fill;
            fill = '0;
            head_slot = '0;
            tail_slot = '0;
            unsent = '0;
         end
      endcase
      o.accepted = (o.code == ERR_NONE);
      o.pending = fill;
      o.outstanding = unsent;
      if (fill != 0) begin
         o.head_id = slot_id[head_slot];
         o.head_left = slot_len[head_slot] - slot_off[head_slot];
         o.head_att = slot_att[head_slot];
      end
      return o;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void plan_request(kind_type k, int plen, int wb, bit ok);
      request_t r;
      r.kind = k;
      r.plen = 16'(plen);
      r.wbytes = 16'(wb);
      r.ok = ok;
      case (k)
         KIND_ENQUEUE: begin
            if (r.plen != 0 && plan_left.size() < items_cap()
                && int'(plan_bytes) + int'(r.plen) <= byte_cap()) begin
               plan_left.push_back(r.plen);
               plan_bytes += r.plen;
            end
         end
         KIND_WRITTEN: begin
            if (plan_left.size() != 0 && r.wbytes != 0 && r.wbytes <= plan_left[0]) begin
               plan_left[0] -= r.wbytes;
               plan_bytes -= r.wbytes;
            end
         end
         KIND_COMPLETE: begin
            if (plan_left.size() != 0 && ok && plan_left[0] == 0)
               void'(plan_left.pop_front());
         end
         default: begin
            plan_left.delete();
            plan_bytes = 0;
         end
      endcase
      backlog.push_back(r);
      requests_planned++;
   endfunction

   function automatic int pick_length();
      int room;
      room = byte_cap() - int'(plan_bytes);
      case ($urandom_range(0, 9))
         0, 1: return $urandom_range(1, 65535);
         2: begin
            if (room >= 1 && room <= 65535) return room;
            return $urandom_range(1, 64);
         end
         default: return $urandom_range(1, 1500);
      endcase
   endfunction

   function automatic void plan_random();
      int roll;
      int depth_now;
      int wb;
      roll = $urandom_range(0, 99);
      depth_now = plan_left.size();
      wb = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
      if (roll < 2) begin
         plan_request(KIND_CANCEL, $urandom_range(0, 65535), wb, 1'($urandom));
      end else if (roll < 17) begin
         plan_request(kind_type'($urandom_range(0, 2)), $urandom_range(0, 65535), wb,
                      1'($urandom));
      end else if (depth_now == 0 || (depth_now < items_cap() && $urandom_range(0, 2) == 0)) begin
         plan_request(KIND_ENQUEUE, pick_length(), wb, 1'($urandom));
      end else if (plan_left[0] == 0) begin
         plan_request(KIND_COMPLETE, $urandom_range(0, 65535), wb, $urandom_range(0, 7) != 0);
      end else if ($urandom_range(0, 9) == 0) begin
         plan_request(KIND_COMPLETE, $urandom_range(0, 65535), wb, 1'($urandom));
      end else begin
         plan_request(KIND_WRITTEN, $urandom_range(0, 65535),
                      ($urandom_range(0, 2) == 0) ? plan_left[0]
                                                   : $urandom_range(1, plan_left[0]),
                      1'($urandom));
      end
   endfunction

   task automatic wait_idle();
      while (requests_taken != requests_planned || replies_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_limits(int items, int bytes);
      wait_idle();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_MAX_ITEMS;
      csr_wdata <= CSR_DATA_W'(items);
      @(negedge clock);
      csr_index <= CSR_MAX_BYTES;
      csr_wdata <= CSR_DATA_W'(bytes);
      @(negedge clock);
      csr_write <= 1'b0;
      cfg_items = 5'(items);
      cfg_bytes = 21'(bytes);
   endtask

   // request driver
   always @(negedge clock) begin : drive_requests
      request_t r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 24) == 0) begin
            send_gap <= $urandom_range(0, 14);
            req_valid <= 1'b0;
         end else if (backlog.size() != 0) begin
            r = backlog.pop_front();
            req_valid <= 1'b1;
            req_kind <= r.kind;
            req_payload_length <= r.plen;
            req_written_bytes <= r.wbytes;
            req_success <= r.ok;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall bursts
   always @(negedge clock) begin
      if (stall_gap > 0) begin
         stall_gap <= stall_gap - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         stall_gap <= $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // acceptance, prediction and response checking
   always @(posedge clock) begin : watch_ports
      request_t seen;
      reply_t   want;
      if (reset) begin
         req_taken <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
               check_field("error_code", 32'(want.code), 32'(rsp_error_code));
               check_field("new_item_id", want.new_id, rsp_new_item_id);
               check_field("cancelled_count", 32'(want.cancelled), 32'(rsp_cancelled_count));
               check_field("pending_count", 32'(want.pending), 32'(rsp_pending_count));
               check_field("outstanding_bytes", 32'(want.outstanding),
                           32'(rsp_outstanding_bytes));
               check_field("head_id", want.head_id, rsp_head_id);
               check_field("head_remaining", 32'(want.head_left), 32'(rsp_head_remaining));
               check_field("head_attempts", 32'(want.head_att), 32'(rsp_head_attempts));
            end
         end
         if (req_valid && !req_stall) begin
            seen.kind = kind_type'(req_kind);
            seen.plen = req_payload_length;
            seen.wbytes = req_written_bytes;
            seen.ok = req_success;
            replies_due.push_back(track_request(seen));
            requests_taken++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog
   initial begin
      while (quiet_cycles < WATCH_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin : run_phases
      int k;
      int pick;
      for (k = 0; k < SLOTS; k++) begin
         slot_len[k] = '0;
         slot_off[k] = '0;
         slot_att[k] = '0;
         slot_id[k] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue, zero length, progress errors, completion outcomes, cancel
      plan_request(KIND_WRITTEN, 0, 5, 1'b1);
      plan_request(KIND_COMPLETE, 0, 0, 1'b1);
      plan_request(KIND_ENQUEUE, 0, 0, 1'b0);
      plan_request(KIND_ENQUEUE, 65535, 0, 1'b0);
      plan_request(KIND_WRITTEN, 0, 0, 1'b0);
      plan_request(KIND_WRITTEN, 0, 1000, 1'b0);
      plan_request(KIND_WRITTEN, 0, 65535, 1'b1);
      plan_request(KIND_COMPLETE, 0, 0, 1'b0);
      plan_request(KIND_COMPLETE, 0, 0, 1'b1);
      plan_request(KIND_WRITTEN, 0, 64535, 1'b0);
      plan_request(KIND_ENQUEUE, 1, 0, 1'b0);
      plan_request(KIND_COMPLETE, 0, 0, 1'b1);
      plan_request(KIND_CANCEL, 65535, 65535, 1'b1);
      plan_request(KIND_CANCEL, 0, 0, 1'b0);

      // zero limits act as one
      set_limits(0, 0);
      plan_request(KIND_ENQUEUE, 1, 0, 1'b1);
      plan_request(KIND_ENQUEUE, 0, 0, 1'b1);
      plan_request(KIND_ENQUEUE, 5, 0, 1'b1);
      plan_request(KIND_CANCEL, 0, 0, 1'b1);

      // budget edge and full before budget
      set_limits(2, 100);
      plan_request(KIND_ENQUEUE, 60, 0, 1'b1);
      plan_request(KIND_ENQUEUE, 41, 0, 1'b1);
      plan_request(KIND_ENQUEUE, 40, 0, 1'b1);
      plan_request(KIND_ENQUEUE, 1, 0, 1'b1);
      plan_request(KIND_WRITTEN, 0, 60, 1'b1);
      plan_request(KIND_COMPLETE, 0, 0, 1'b1);
      plan_request(KIND_CANCEL, 0, 0, 1'b1);

      set_limits(16, 1048576);
      repeat (200) plan_random();
      set_limits(31, 2097151);
      repeat (200) plan_random();
      set_limits(1, 65535);
      repeat (150) plan_random();
      set_limits(0, 0);
      repeat (100) plan_random();
      set_limits(4, 3000);
      repeat (200) plan_random();

      // pile failed attempts onto a single head entry
      set_limits(2, 1000);
      plan_request(KIND_ENQUEUE, 10, 0, 1'b1);
      for (k = 0; k < SAT_OPS; k++) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) plan_request(KIND_COMPLETE, 0, 0, 1'b0);
         else if (pick < 7) plan_request(KIND_COMPLETE, 0, 0, 1'b1);
         else if (pick < 9) plan_request(KIND_WRITTEN, 0, $urandom_range(11, 65535), 1'b1);
         else plan_request(KIND_WRITTEN, 0, 0, 1'b1);
      end
      plan_request(KIND_WRITTEN, 0, 10, 1'b1);
      plan_request(KIND_COMPLETE, 0, 0, 1'b1);
      repeat (150) plan_random();

      repeat (3) begin
         set_limits($urandom_range(0, 31),
                    $urandom_range(0, 1) ? $urandom_range(0, 2097151)
                                         : $urandom_range(0, 5000));
         repeat (150) plan_random();
      end

      set_limits(16, 1048576);
      calm = 1'b1;
      repeat (250) plan_random();

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && replies_due.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/sqbb_pkg.sv
rtl/sqbb_store.sv
rtl/sqbb_exec.sv
rtl/send_queue_byte_budget_core.sv
tb/send_queue_byte_budget_core_test.sv
